### src/dpm_pkg.sv
`timescale 1ns / 1ps

package dpm_pkg;

   localparam int PeriodWidth = 16;
   localparam int OverflowWidth = 6;
   localparam int CaptureShift = 6;

   localparam logic [PeriodWidth-1:0] PERIOD_STOPPED = 16'hFFFF;
   localparam logic [3:0] WHEEL_TIMEOUT_PHASE = 4'hF;

   typedef enum logic [1:0] {
      OP_RPM_CAPTURE = 2'd0,
      OP_SPEED_CHECK = 2'd1,
      OP_OVERFLOW    = 2'd2
   } op_type;

   typedef struct packed {
      logic [1:0]             operation;
      logic [PeriodWidth-1:0] capture_value;
      logic                   pin_level;
   } req_type;

   typedef struct packed {
      logic [PeriodWidth-1:0] rpm_period;
      logic [PeriodWidth-1:0] wheel_period;
      logic                   rotation;
      logic                   activity;
   } rsp_type;

endpackage

### src/dpm_core.sv
`timescale 1ns / 1ps

module dpm_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  dpm_pkg::req_type req,
   output dpm_pkg::rsp_type res
);
   import dpm_pkg::*;

   logic [PeriodWidth-1:0]   rpm_newest_ff, rpm_newest_in;
   logic [PeriodWidth-1:0]   rpm_older_ff, rpm_older_in;
   logic [PeriodWidth-1:0]   last_rpm_capture_ff, last_rpm_capture_in;
   logic [PeriodWidth-1:0]   last_wheel_stamp_ff, last_wheel_stamp_in;
   logic [PeriodWidth-1:0]   wheel_period_ff, wheel_period_in;
   logic                     rpm_idle_ff, rpm_idle_in;
   logic                     wheel_idle_ff, wheel_idle_in;
   logic [OverflowWidth-1:0] overflow_count_ff, overflow_count_in;

   logic [PeriodWidth-1:0]   wheel_stamp;
   logic [OverflowWidth-1:0] overflow_next;
   logic [PeriodWidth+1:0]   scaled_new;
   logic [PeriodWidth+1:0]   scaled_old;
   logic                     rotation;
   logic                     activity;

   // The coarse stamp packs the overflow count above the upper capture bits.
   assign wheel_stamp = {overflow_count_ff, req.capture_value[PeriodWidth-1:CaptureShift]};
   assign overflow_next = overflow_count_ff + 1'b1;

   always_comb begin
      rpm_newest_in = rpm_newest_ff;
      rpm_older_in = rpm_older_ff;
      last_rpm_capture_in = last_rpm_capture_ff;
      last_wheel_stamp_in = last_wheel_stamp_ff;
      wheel_period_in = wheel_period_ff;
      rpm_idle_in = rpm_idle_ff;
      wheel_idle_in = wheel_idle_ff;
      overflow_count_in = overflow_count_ff;
      rotation = 1'b0;
      activity = 1'b0;
      if (step) begin
         case (op_type'(req.operation))
            OP_RPM_CAPTURE: begin
               rpm_older_in = rpm_newest_ff;
               rpm_newest_in = req.capture_value - last_rpm_capture_ff;
               last_rpm_capture_in = req.capture_value;
               rpm_idle_in = 1'b0;
               activity = 1'b1;
            end
            OP_SPEED_CHECK: begin
               if (!req.pin_level) begin
                  if (last_wheel_stamp_ff != PERIOD_STOPPED) begin
                     wheel_period_in = wheel_stamp - last_wheel_stamp_ff;
                  end
                  last_wheel_stamp_in = wheel_stamp;
                  wheel_idle_in = 1'b0;
                  rotation = 1'b1;
                  activity = 1'b1;
               end
            end
            OP_OVERFLOW: begin
               if (rpm_idle_ff) begin
                  rpm_newest_in = PERIOD_STOPPED;
                  rpm_older_in = PERIOD_STOPPED;
               end
               rpm_idle_in = 1'b1;
               overflow_count_in = overflow_next;
               if (overflow_next[3:0] == WHEEL_TIMEOUT_PHASE) begin
                  if (wheel_idle_ff) begin
                     wheel_period_in = PERIOD_STOPPED;
                     last_wheel_stamp_in = PERIOD_STOPPED;
                  end
                  wheel_idle_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The newest period is taken as a missed pulse when it is below three
   // quarters of the older one, compared exactly as 4*new < 3*old.
   assign scaled_new = {rpm_newest_in, 2'b00};
   assign scaled_old = {2'b00, rpm_older_in} + {1'b0, rpm_older_in, 1'b0};

   assign res.rpm_period = (scaled_new < scaled_old) ? rpm_older_in : rpm_newest_in;
   assign res.wheel_period = wheel_period_in;
   assign res.rotation = rotation;
   assign res.activity = activity;

   always_ff @(posedge clock) begin
      if (reset) begin
         rpm_newest_ff <= PERIOD_STOPPED;
         rpm_older_ff <= PERIOD_STOPPED;
         last_rpm_capture_ff <= '0;
         last_wheel_stamp_ff <= '0;
         wheel_period_ff <= PERIOD_STOPPED;
         rpm_idle_ff <= 1'b1;
         wheel_idle_ff <= 1'b1;
         overflow_count_ff <= '0;
      end else begin
         rpm_newest_ff <= rpm_newest_in;
         rpm_older_ff <= rpm_older_in;
         last_rpm_capture_ff <= last_rpm_capture_in;
         last_wheel_stamp_ff <= last_wheel_stamp_in;
         wheel_period_ff <= wheel_period_in;
         rpm_idle_ff <= rpm_idle_in;
         wheel_idle_ff <= wheel_idle_in;
         overflow_count_ff <= overflow_count_in;
      end
   end

   a_capture_clears_idle: assert property (@(posedge clock) disable iff (reset)
      step && req.operation == OP_RPM_CAPTURE |=> !rpm_idle_ff)
      else $error("rpm capture did not clear the idle flag");

   a_rpm_timeout: assert property (@(posedge clock) disable iff (reset)
      step && req.operation == OP_OVERFLOW && rpm_idle_ff
      |=> rpm_newest_ff == PERIOD_STOPPED && rpm_older_ff == PERIOD_STOPPED)
      else $error("rpm periods not stopped after two idle overflows");

   a_overflow_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(step && req.operation == OP_OVERFLOW) |=> $stable(overflow_count_ff))
      else $error("overflow count changed without an overflow request");

   a_rotation_activity: assert property (@(posedge clock) disable iff (reset)
      res.rotation |-> res.activity && step && req.operation == OP_SPEED_CHECK)
      else $error("rotation flagged without a valid speed check");

endmodule

### src/dual_period_meter_with_timeout.sv
`timescale 1ns / 1ps

// Dual period meter with timeout.
// Each request on the req_ channel is one timer event: an rpm capture, a
// delayed speed edge check with the pin level, or a timer overflow tick.
// Every request yields exactly one response on the rsp_ channel, carrying the
// selected rpm period, the wheel period after the event, and the rotation and
// activity flags. A period of 65535 means the input is stopped.
// A request is registered on acceptance and processed into the response
// register once that register is empty or being read by the receiver.
// One request per cycle is sustained while every response is taken; the
// only loop is the update of the measurement registers in the core.
// Reset clears both stages and returns all periods to stopped, the capture
// history to zero and the overflow count to zero.
// When the receiver stalls, the response register holds its result, the
// input register keeps one more request, and req_ready falls only when both
// are full.
module dual_period_meter_with_timeout (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_operation,
   input  logic [dpm_pkg::PeriodWidth-1:0]  req_capture_value,
   input  logic                             req_pin_level,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [dpm_pkg::PeriodWidth-1:0]  rsp_rpm_period,
   output logic [dpm_pkg::PeriodWidth-1:0]  rsp_wheel_period,
   output logic                             rsp_rotation,
   output logic                             rsp_activity
);
   import dpm_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_req_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff;
   rsp_type core_rsp;
   logic    advance;
   logic    take;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take = req_valid && req_ready;

   assign in_valid_in = take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   dpm_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_req_ff),
      .res   (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_req_ff.operation <= req_operation;
         in_req_ff.capture_value <= req_capture_value;
         in_req_ff.pin_level <= req_pin_level;
      end
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_rpm_period = out_rsp_ff.rpm_period;
   assign rsp_wheel_period = out_rsp_ff.wheel_period;
   assign rsp_rotation = out_rsp_ff.rotation;
   assign rsp_activity = out_rsp_ff.activity;

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

import dpm_pkg::*;

class period_scoreboard;
   logic [PeriodWidth-1:0]   rpm_newest;
   logic [PeriodWidth-1:0]   rpm_older;
   logic [PeriodWidth-1:0]   last_capture;
   logic [PeriodWidth-1:0]   last_stamp;
   logic [PeriodWidth-1:0]   wheel_period;
   logic                     rpm_idle;
   logic                     wheel_idle;
   logic [OverflowWidth-1:0] overflow_count;

   rsp_type expected_rsp[$];
   int      mismatches;
   int      checked;
   int      captures;
   int      speed_checks;
   int      bounces;
   int      overflows;
   int      unused_codes;
   int      older_selected;
   int      rpm_timeouts;
   int      wheel_timeouts;

   function new();
      rpm_newest     = PERIOD_STOPPED;
      rpm_older      = PERIOD_STOPPED;
      last_capture   = '0;
      last_stamp     = '0;
      wheel_period   = PERIOD_STOPPED;
      rpm_idle       = 1'b1;
      wheel_idle     = 1'b1;
      overflow_count = '0;
      mismatches     = 0;
      checked        = 0;
      captures       = 0;
      speed_checks   = 0;
      bounces        = 0;
      overflows      = 0;
      unused_codes   = 0;
      older_selected = 0;
      rpm_timeouts   = 0;
      wheel_timeouts = 0;
   endfunction

   function void note_request(logic [1:0] op, logic [PeriodWidth-1:0] cap, logic pin);
      rsp_type                rsp;
      logic [PeriodWidth-1:0] stamp;
      int unsigned            scaled_new;
      int unsigned            scaled_old;
      rsp.rotation = 1'b0;
      rsp.activity = 1'b0;
      case (op)
         OP_RPM_CAPTURE: begin
            rpm_older    = rpm_newest;
            rpm_newest   = cap - last_capture;
            last_capture = cap;
            rpm_idle     = 1'b0;
            rsp.activity = 1'b1;
            captures++;
         end
         OP_SPEED_CHECK: begin
            speed_checks++;
            if (pin) begin
               bounces++;
            end else begin
               stamp = {overflow_count, 10'b0} + {6'b0, cap[PeriodWidth-1:CaptureShift]};
               if (last_stamp != PERIOD_STOPPED) begin
                  wheel_period = stamp - last_stamp;
               end
               last_stamp   = stamp;
               wheel_idle   = 1'b0;
               rsp.rotation = 1'b1;
               rsp.activity = 1'b1;
            end
         end
         OP_OVERFLOW: begin
            overflows++;
            if (rpm_idle) begin
               if (rpm_newest != PERIOD_STOPPED || rpm_older != PERIOD_STOPPED) begin
                  rpm_timeouts++;
               end
               rpm_newest = PERIOD_STOPPED;
               rpm_older  = PERIOD_STOPPED;
            end
            rpm_idle       = 1'b1;
            overflow_count = overflow_count + 1'b1;
            if (overflow_count[3:0] == WHEEL_TIMEOUT_PHASE) begin
               if (wheel_idle) begin
                  if (wheel_period != PERIOD_STOPPED) begin
                     wheel_timeouts++;
                  end
                  wheel_period = PERIOD_STOPPED;
                  last_stamp   = PERIOD_STOPPED;
               end
               wheel_idle = 1'b1;
            end
         end
         default: begin
            unused_codes++;
         end
      endcase
      scaled_new = 32'(rpm_newest) * 4;
      scaled_old = 32'(rpm_older) * 3;
      if (scaled_new < scaled_old) begin
         rsp.rpm_period = rpm_older;
         older_selected++;
      end else begin
         rsp.rpm_period = rpm_newest;
      end
      rsp.wheel_period = wheel_period;
      expected_rsp.push_back(rsp);
   endfunction

   function void check_response(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Unexpected response: rpm %h wheel %h rot %b act %b",
                     got.rpm_period, got.wheel_period, got.rotation, got.activity);
         end
         return;
      end
      want = expected_rsp.pop_front();
      checked++;
      if (got.rpm_period !== want.rpm_period || got.wheel_period !== want.wheel_period ||
          got.rotation !== want.rotation || got.activity !== want.activity) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Mismatch on response %0d: expected rpm %h wheel %h rot %b act %b,",
                     checked, want.rpm_period, want.wheel_period, want.rotation,
                     want.activity);
            $display("   got rpm %h wheel %h rot %b act %b",
                     got.rpm_period, got.wheel_period, got.rotation, got.activity);
         end
      end
   endfunction

   function int pending();
      return expected_rsp.size();
   endfunction
endclass

module tb;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CycleLimit = 400000;
   localparam int PhaseItems = 370;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [1:0]             req_operation;
   logic [PeriodWidth-1:0] req_capture_value;
   logic                   req_pin_level;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [PeriodWidth-1:0] rsp_rpm_period;
   logic [PeriodWidth-1:0] rsp_wheel_period;
   logic                   rsp_rotation;
   logic                   rsp_activity;

   period_scoreboard       board;
   int                     idle_pct;
   int                     stall_pct;
   int                     cycles = 0;
   int                     sent;
   logic [PeriodWidth-1:0] engine_clock;

   dual_period_meter_with_timeout uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_capture_value(req_capture_value),
      .req_pin_level    (req_pin_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_rpm_period   (rsp_rpm_period),
      .rsp_wheel_period (rsp_wheel_period),
      .rsp_rotation     (rsp_rotation),
      .rsp_activity     (rsp_activity)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("Run stopped after %0d cycles with %0d responses outstanding.",
                  cycles, board.pending());
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         got.rpm_period   = rsp_rpm_period;
         got.wheel_period = rsp_wheel_period;
         got.rotation     = rsp_rotation;
         got.activity     = rsp_activity;
         board.check_response(got);
      end
   end

   task automatic send_request(logic [1:0] op, logic [PeriodWidth-1:0] cap, logic pin);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_capture_value <= cap;
      req_pin_level     <= pin;
      do @(posedge clock); while (req_ready !== 1'b1);
      board.note_request(op, cap, pin);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_capture();
      logic [PeriodWidth-1:0] period;
      if ($urandom_range(3) == 0) begin
         period = 16'($urandom_range(65535));
      end else begin
         period = 16'($urandom_range(3000, 200));
      end
      engine_clock = engine_clock + period;
      send_request(OP_RPM_CAPTURE, engine_clock, 1'b0);
   endtask

   task automatic send_burst();
      int mode;
      int len;
      int pick;
      mode = $urandom_range(9);
      len  = (mode inside {6, 7}) ? $urandom_range(70, 40) : $urandom_range(40, 8);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(99);
         if (mode <= 5) begin
            if (pick < 35) begin
               send_capture();
            end else if (pick < 65) begin
               send_request(OP_SPEED_CHECK, 16'($urandom_range(65535)),
                            $urandom_range(4) == 0);
            end else if (pick < 96) begin
               send_request(OP_OVERFLOW, 16'($urandom_range(65535)),
                            1'($urandom_range(1)));
            end else begin
               send_request(OP_UNUSED, 16'($urandom_range(65535)),
                            1'($urandom_range(1)));
            end
         end else if (mode <= 7) begin
            if (pick < 40) begin
               send_capture();
            end else begin
               send_request(OP_OVERFLOW, 16'($urandom_range(65535)),
                            1'($urandom_range(1)));
            end
         end else if (mode == 8) begin
            if (pick < 60) begin
               send_request(OP_SPEED_CHECK, 16'($urandom_range(65535)),
                            1'($urandom_range(1)));
            end else begin
               send_request(OP_OVERFLOW, 16'($urandom_range(65535)),
                            1'($urandom_range(1)));
            end
         end else begin
            send_request(2'($urandom_range(3)), 16'($urandom_range(65535)),
                         1'($urandom_range(1)));
         end
      end
   endtask

   task automatic run_phase(int sender_idle, int receiver_stall);
      int target;
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      target    = sent + PhaseItems;
      while (sent < target) begin
         send_burst();
      end
   endtask

   initial begin
      board             = new();
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_operation     = OP_RPM_CAPTURE;
      req_capture_value = '0;
      req_pin_level     = 1'b0;
      idle_pct          = 0;
      stall_pct         = 0;
      sent              = 0;
      engine_clock      = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(OP_UNUSED, 16'hFFFF, 1'b1);
      send_request(OP_RPM_CAPTURE, 16'h0000, 1'b0);
      send_request(OP_RPM_CAPTURE, 16'hFFFF, 1'b1);
      send_request(OP_RPM_CAPTURE, 16'h0000, 1'b0);
      send_request(OP_RPM_CAPTURE, 16'd1000, 1'b0);
      send_request(OP_RPM_CAPTURE, 16'd2000, 1'b0);
      send_request(OP_RPM_CAPTURE, 16'd2500, 1'b0);
      send_request(OP_RPM_CAPTURE, 16'd2504, 1'b0);
      send_request(OP_RPM_CAPTURE, 16'd2507, 1'b0);
      send_request(OP_SPEED_CHECK, 16'hFFFF, 1'b1);
      send_request(OP_SPEED_CHECK, 16'hFFFF, 1'b0);
      send_request(OP_SPEED_CHECK, 16'h0000, 1'b0);
      send_request(OP_SPEED_CHECK, 16'h003F, 1'b0);
      send_request(OP_OVERFLOW, 16'hFFFF, 1'b1);
      send_request(OP_OVERFLOW, 16'h0000, 1'b0);
      send_request(OP_OVERFLOW, 16'h0000, 1'b0);
      send_request(OP_UNUSED, 16'h0000, 1'b0);
      for (int i = 0; i < 34; i++) begin
         send_request(OP_OVERFLOW, 16'h5555, i[0]);
      end
      send_request(OP_SPEED_CHECK, 16'hAAAA, 1'b0);
      send_request(OP_SPEED_CHECK, 16'h5555, 1'b0);

      run_phase(0, 0);
      run_phase(64, 0);
      run_phase(0, 64);
      run_phase(38, 38);

      req_valid <= 1'b0;
      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d requests: %0d rpm captures, %0d speed checks (%0d bounced),",
               sent, board.captures, board.speed_checks, board.bounces);
      $display("%0d overflow ticks, %0d unused codes; %0d rpm and %0d wheel timeouts.",
               board.overflows, board.unused_codes, board.rpm_timeouts,
               board.wheel_timeouts);
      if (board.mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches in %0d responses.", board.mismatches, board.checked);
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
